### rtl/shamh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher package
// Round constants, initial hash value, sigma functions and the control
// bundles that the sequencer sends to the schedule and compression units.
// ----------------------------------------------------------------------------
package shamh_pkg;

  localparam int WordW   = 32;
  localparam int NumWords = 8;
  localparam int DigestW = WordW * NumWords;
  localparam int BlockW  = 512;

  // Standard initial hash value, word 0 in the top bits.
  localparam logic [DigestW-1:0] InitHash = {
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  // Control toward the message schedule window.
  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       step;
  } sched_ctl_t;

  // Control toward the compression unit.
  typedef struct packed {
    logic       init;
    logic       load;
    logic       round;
    logic       add;
    logic [5:0] rnd;
  } cmp_ctl_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    ror32 = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] v);
    big_sigma0 = ror32(v, 2) ^ ror32(v, 13) ^ ror32(v, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] v);
    big_sigma1 = ror32(v, 6) ^ ror32(v, 11) ^ ror32(v, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] v);
    small_sigma0 = ror32(v, 7) ^ ror32(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] v);
    small_sigma1 = ror32(v, 17) ^ ror32(v, 19) ^ (v >> 10);
  endfunction

  // Round constant table.
  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
      6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
      6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
      6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
      6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
      6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
      6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
      6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
      6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
      6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
      6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
      6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
      6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
      6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
      6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
      6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
      6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
      6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
      6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
      6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
      6'd62: k = 32'hBEF9A3F7;  6'd63: k = 32'hC67178F2;
    endcase
    return k;
  endfunction

endpackage

### rtl/shamh_if.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher channel interfaces
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface shamh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output has_byte, output is_last,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input is_last,
                  output ready);
endinterface

interface shamh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

### rtl/shamh_sched.sv
// ----------------------------------------------------------------------------
// SHA-256 message schedule window
// A 512-bit shift line that gathers message bytes into the block and then
// slides one expanded schedule word per round.
// ----------------------------------------------------------------------------
module shamh_sched (
  input  logic                 clk,
  input  shamh_pkg::sched_ctl_t ctl,
  output logic [31:0]          w_cur
);
  import shamh_pkg::*;

  logic [BlockW-1:0] window_r;
  logic [31:0]       w_new;

  // Top word is w[t]; the words below it follow in schedule order.
  assign w_cur = window_r[BlockW-1 -: 32];

  // Next schedule word from w[t], w[t+1], w[t+9] and w[t+14].
  assign w_new = window_r[BlockW-1 -: 32]
               + small_sigma0(window_r[BlockW-1-32 -: 32])
               + window_r[BlockW-1-32*9 -: 32]
               + small_sigma1(window_r[BlockW-1-32*14 -: 32]);

  // Bytes shift in during fill; words shift in during rounds.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      window_r <= {window_r[BlockW-9:0], ctl.push_byte};
    end else if (ctl.step) begin
      window_r <= {window_r[BlockW-33:0], w_new};
    end
  end

endmodule

### rtl/shamh_compress.sv
// ----------------------------------------------------------------------------
// SHA-256 compression unit
// Holds the chaining value and the eight working words, and runs one
// compression round per cycle under control of the sequencer.
// ----------------------------------------------------------------------------
module shamh_compress (
  input  logic                   clk,
  input  logic                   rst_n,
  input  shamh_pkg::cmp_ctl_t    ctl,
  input  logic [31:0]            w_cur,
  output logic [shamh_pkg::DigestW-1:0] chain
);
  import shamh_pkg::*;

  logic [31:0] chain_r [NumWords];
  logic [31:0] work_r  [NumWords];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  // Round function on the working words a..h.
  always_comb begin
    ch  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
    maj = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
    t1  = work_r[7] + big_sigma1(work_r[4]) + ch + round_k(ctl.rnd) + w_cur;
    t2  = big_sigma0(work_r[0]) + maj;
  end

  // Working words: load from the chain, then rotate through the rounds.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < NumWords; i++) begin
        work_r[i] <= chain_r[i];
      end
    end else if (ctl.round) begin
      work_r[0] <= t1 + t2;
      work_r[1] <= work_r[0];
      work_r[2] <= work_r[1];
      work_r[3] <= work_r[2];
      work_r[4] <= work_r[3] + t1;
      work_r[5] <= work_r[4];
      work_r[6] <= work_r[5];
      work_r[7] <= work_r[6];
    end
  end

  // Chaining value: initial value on reset or new message, feed-forward add
  // at the end of each block.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      for (int i = 0; i < NumWords; i++) begin
        chain_r[i] <= InitHash[DigestW-1-32*i -: 32];
      end
    end else if (ctl.add) begin
      for (int i = 0; i < NumWords; i++) begin
        chain_r[i] <= chain_r[i] + work_r[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumWords; i++) begin
      chain[DigestW-1-32*i -: 32] = chain_r[i];
    end
  end

endmodule

### rtl/sha256_message_hasher_core.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher core
// Takes a message one byte per beat, compresses each 64-byte block, pads
// the message on the last beat and returns the eight digest words, with an
// optional second hash of the digest.
//
//   Channel   Direction  Payload                               Beat
//   in_ch     sink       data_byte[7:0], has_byte, is_last     one message byte
//   out_ch    source     digest_word[31:0], word_index[2:0],   one digest word
//                        last_word
//   cfg_*     write      cfg_wdata = double_hash               register write
//
// The 64th byte of a block starts load, 64 rounds and feed-forward in the
// shared round unit.
// The last beat adds the pad bytes (9 to 72 bytes, ending in the length field),
// the compression of each padded block (one or two) and the digest capture,
// then eight output beats; double mode adds 32 digest bytes, 32 pad bytes,
// one more compression and one more digest capture.
// in_ch.ready is high only while the sequencer is idle; output stalls hold
// the sequencer in the output state. Reset is synchronous and needs no sweep.
// ----------------------------------------------------------------------------
module sha256_message_hasher_core (
  input  logic clk,
  input  logic rst_n,
  shamh_in_if.sink   in_ch,
  shamh_out_if.source out_ch,
  input  logic cfg_we,
  input  logic cfg_wdata
);
  import shamh_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_ROUND  = 4'd2;
  localparam logic [3:0] S_ADD    = 4'd3;
  localparam logic [3:0] S_FIN    = 4'd4;
  localparam logic [3:0] S_REHASH = 4'd5;
  localparam logic [3:0] S_PAD    = 4'd6;
  localparam logic [3:0] S_LEN    = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  localparam logic [5:0] LastByte   = 6'd63;
  localparam logic [5:0] LenOffset  = 6'd56;
  localparam logic [5:0] LastDigByte = 6'd31;
  localparam logic [60:0] DigestBytes = 61'd32;

  logic [3:0]         state_r, state_nxt;
  logic [5:0]         fill_r, fill_nxt;
  logic [60:0]        bc_r, bc_nxt;
  logic [5:0]         rnd_r, rnd_nxt;
  logic [2:0]         oidx_r, oidx_nxt;
  logic [DigestW-1:0] dig_r, dig_nxt;
  logic               pad_r, pad_nxt;
  logic               mk_r, mk_nxt;
  logic               fin_r, fin_nxt;
  logic               pass2_r, pass2_nxt;
  logic               dbl_r, dbl_nxt;
  logic               cfg_dbl_r;

  sched_ctl_t         sctl;
  cmp_ctl_t           cctl;
  logic [31:0]        w_cur;
  logic [DigestW-1:0] chain;
  logic [63:0]        len_bits;
  logic [7:0]         len_byte;
  logic               in_acc;
  logic               out_acc;

  shamh_sched u_sched (
    .clk   (clk),
    .ctl   (sctl),
    .w_cur (w_cur)
  );

  shamh_compress u_compress (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cctl),
    .w_cur (w_cur),
    .chain (chain)
  );

  // Handshakes and the output register view.
  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_acc             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_acc            = out_ch.valid && out_ch.ready;
  assign out_ch.digest_word = dig_r[DigestW-1 -: 32];
  assign out_ch.word_index  = oidx_r;
  assign out_ch.last_word   = (oidx_r == 3'd7);

  // Big-endian bit length; fill positions 56..63 pick bytes 0..7.
  assign len_bits = {bc_r, 3'b000};
  assign len_byte = len_bits[{~fill_r[2:0], 3'b000} +: 8];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_dbl_r <= 1'b0;
    end else if (cfg_we) begin
      cfg_dbl_r <= cfg_wdata;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    bc_nxt    = bc_r;
    rnd_nxt   = rnd_r;
    oidx_nxt  = oidx_r;
    dig_nxt   = dig_r;
    pad_nxt   = pad_r;
    mk_nxt    = mk_r;
    fin_nxt   = fin_r;
    pass2_nxt = pass2_r;
    dbl_nxt   = dbl_r;
    sctl      = '0;
    cctl      = '0;
    cctl.rnd  = rnd_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.is_last) begin
            dbl_nxt = cfg_dbl_r;
          end
          if (in_ch.has_byte) begin
            sctl.push      = 1'b1;
            sctl.push_byte = in_ch.data_byte;
            bc_nxt         = bc_r + 61'd1;
          end
          if (in_ch.has_byte && fill_r == LastByte) begin
            pad_nxt   = in_ch.is_last;
            state_nxt = S_LOAD;
          end else if (in_ch.is_last) begin
            pad_nxt   = 1'b1;
            state_nxt = S_PAD;
          end
        end
      end
      S_LOAD: begin
        cctl.load = 1'b1;
        rnd_nxt   = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cctl.round = 1'b1;
        sctl.step  = 1'b1;
        rnd_nxt    = rnd_r + 6'd1;
        if (rnd_r == LastByte) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cctl.add = 1'b1;
        if (fin_r) begin
          state_nxt = S_FIN;
        end else if (pad_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        cctl.init = 1'b1;
        dig_nxt   = chain;
        fill_nxt  = '0;
        pad_nxt   = 1'b0;
        mk_nxt    = 1'b0;
        fin_nxt   = 1'b0;
        if (dbl_r && !pass2_r) begin
          bc_nxt    = DigestBytes;
          pass2_nxt = 1'b1;
          state_nxt = S_REHASH;
        end else begin
          bc_nxt    = '0;
          pass2_nxt = 1'b0;
          oidx_nxt  = '0;
          state_nxt = S_OUT;
        end
      end
      S_REHASH: begin
        sctl.push      = 1'b1;
        sctl.push_byte = dig_r[DigestW-1 -: 8];
        dig_nxt        = {dig_r[DigestW-9:0], 8'h00};
        if (fill_r == LastDigByte) begin
          pad_nxt   = 1'b1;
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        if (!mk_r) begin
          sctl.push      = 1'b1;
          sctl.push_byte = 8'h80;
          mk_nxt         = 1'b1;
        end else if (fill_r == LenOffset) begin
          state_nxt = S_LEN;
        end else begin
          sctl.push      = 1'b1;
          sctl.push_byte = 8'h00;
        end
        if (sctl.push && fill_r == LastByte) begin
          state_nxt = S_LOAD;
        end
      end
      S_LEN: begin
        sctl.push      = 1'b1;
        sctl.push_byte = len_byte;
        if (fill_r == LastByte) begin
          fin_nxt   = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          dig_nxt  = {dig_r[DigestW-33:0], 32'h0};
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Every byte push advances the fill count; it wraps at a full block.
    if (sctl.push && state_r != S_FIN) begin
      fill_nxt = fill_r + 6'd1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      bc_r    <= '0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      pad_r   <= 1'b0;
      mk_r    <= 1'b0;
      fin_r   <= 1'b0;
      pass2_r <= 1'b0;
      dbl_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      bc_r    <= bc_nxt;
      rnd_r   <= rnd_nxt;
      oidx_r  <= oidx_nxt;
      pad_r   <= pad_nxt;
      mk_r    <= mk_nxt;
      fin_r   <= fin_nxt;
      pass2_r <= pass2_nxt;
      dbl_r   <= dbl_nxt;
    end
  end

  // Digest hold and output shift register.
  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

  // The input side is never open while digest words are pending.
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while digest output pending");

  // Once the final word is taken the block returns to accepting bytes.
  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last_word |=> in_ch.ready)
    else $error("block not idle after final digest word");

  // The sixty-fourth round is always followed by the feed-forward add.
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND && rnd_r == LastByte |=> state_r == S_ADD)
    else $error("round sequence did not end in feed-forward");

  // Length bytes always start at offset 56 of a block.
  a_len_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PAD && state_nxt == S_LEN |-> fill_r == LenOffset && mk_r)
    else $error("length field started at wrong offset");

endmodule

### dv/sha256_digest_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches the byte channel and the register port, computes the digest each
// message must produce and compares every digest beat that leaves the core.
// ----------------------------------------------------------------------------
module sha256_digest_check (
  input  logic clk,
  input  logic rst_n,
  shamh_in_if  in_ch,
  shamh_out_if out_ch,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   mismatch_count,
  output int   pending_words
);

  // Round constants, round 0 in the top bits.
  localparam logic [64*32-1:0] SHA_K = {
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // Initial hash value, word 0 in the top bits.
  localparam logic [255:0] SHA_IV = {
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic [31:0]  hash_state [8];
  logic [7:0]   blk_bytes [64];
  int           blk_fill;
  logic [60:0]  msg_len;
  logic         dbl_mode;
  digest_beat_t expected_words [$];

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // One 64-round compression of the gathered block into the hash state.
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    int i;
    for (i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    for (i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + SHA_K[(63-i)*32 +: 32] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    blk_bytes[blk_fill] = v;
    blk_fill++;
    if (blk_fill == 64) begin
      compress_block();
      blk_fill = 0;
    end
  endfunction

  function automatic void restart_message();
    int i;
    for (i = 0; i < 8; i++) hash_state[i] = SHA_IV[(7-i)*32 +: 32];
    blk_fill = 0;
    msg_len  = '0;
  endfunction

  // Append 0x80, zeros up to offset 56 and the bit length, big-endian.
  function automatic void pad_message();
    logic [63:0] bit_len;
    int i;
    bit_len = {msg_len, 3'b000};
    absorb_byte(8'h80);
    while (blk_fill != 56) absorb_byte(8'h00);
    for (i = 0; i < 8; i++) absorb_byte(bit_len[8*(7-i) +: 8]);
  endfunction

  // Fold one accepted byte beat into the running hash; a closing beat
  // queues the eight digest words that must follow.
  function automatic void absorb_beat(input logic [7:0] b, input logic h, input logic l);
    logic [31:0] digest [8];
    digest_beat_t beat;
    int i;
    if (h) begin
      absorb_byte(b);
      msg_len++;
    end
    if (l) begin
      pad_message();
      digest = hash_state;
      // Double mode hashes the 32-byte digest as a fresh message.
      if (dbl_mode) begin
        restart_message();
        for (i = 0; i < 32; i++) absorb_byte(digest[i/4][8*(3-(i%4)) +: 8]);
        msg_len = 61'd32;
        pad_message();
        digest = hash_state;
      end
      for (i = 0; i < 8; i++) begin
        beat.word  = digest[i];
        beat.index = 3'(i);
        beat.last  = (i == 7);
        expected_words.push_back(beat);
      end
      restart_message();
    end
  endfunction

  initial begin
    mismatch_count = 0;
    pending_words  = 0;
    dbl_mode       = 1'b0;
    restart_message();
  end

  // Everything is sampled at the rising edge; inputs move on the falling one.
  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst_n) begin
      restart_message();
      dbl_mode = 1'b0;
      expected_words.delete();
    end else begin
      // Digest beat leaving the core.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected digest beat word=%h index=%0d last=%0b", $realtime,
                     out_ch.digest_word, out_ch.word_index, out_ch.last_word);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_ch.digest_word !== want.word || out_ch.word_index !== want.index ||
              out_ch.last_word !== want.last) begin
            if (mismatch_count < 10)
              $display("%0t: digest beat mismatch: expected word=%h index=%0d last=%0b, got word=%h index=%0d last=%0b",
                       $realtime, want.word, want.index, want.last,
                       out_ch.digest_word, out_ch.word_index, out_ch.last_word);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) dbl_mode = cfg_wdata;
      // Byte beat entering the core.
      if (in_ch.valid && in_ch.ready)
        absorb_beat(in_ch.data_byte, in_ch.has_byte, in_ch.is_last);
    end
    pending_words = expected_words.size();
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Feeds messages byte by byte in bursts, stalls the digest channel on its own
// pattern and switches between plain and double hashing, also mid-message.
// The digest checker beside the core predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_ITEMS  = 12;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   mismatch_count;
  int   pending_words;
  int   burst_left;
  int   items_sent;
  int   hold_reqs;
  int   holds_done;
  int   cycle_count;
  logic dbl_setting;

  shamh_in_if  in_if ();
  shamh_out_if out_if ();

  sha256_message_hasher_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  sha256_digest_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_if),
    .out_ch        (out_if),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .pending_words (pending_words)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one beat, with a random gap at the start of each burst, and hold
  // it until the core takes it. Returns on the following falling edge.
  task automatic send_item(input logic [7:0] b, input logic h, input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.has_byte  <= h;
    in_if.is_last   <= l;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    if (h || l) items_sent++;
  endtask

  // Stop offering, wait for every digest word, then let the core finish any
  // compression still under way.
  task automatic settle();
    in_if.valid <= 1'b0;
    wait (pending_words == 0);
    @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic v);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    dbl_setting = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly short messages, often right at the padding and block boundaries.
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 8);
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return 55;
        1: return 56;
        2: return 63;
        default: return 64;
      endcase
    end
    return $urandom_range(0, 130);
  endfunction

  // One message with random content and stray empty beats mixed in. The
  // closing beat carries the final byte or no byte at all. With flip_mid the
  // hash mode is toggled halfway, while the core sits idle mid-message.
  task automatic send_message(input int n_bytes, input bit flip_mid);
    int  i;
    int  body;
    bit  tail_byte;
    tail_byte = (n_bytes > 0) && ($urandom_range(0, 1) == 1);
    body = n_bytes - int'(tail_byte);
    for (i = 0; i < body; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if (flip_mid && i == body / 2) begin
        settle();
        write_cfg(~dbl_setting);
      end
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
    send_item(8'($urandom_range(0, 255)), tail_byte, 1'b1);
  endtask

  // Digest receiver: stalls on its own pattern, plus long hold-offs on request.
  initial begin : sink_pacing
    int mode;
    int span;
    int k;
    int hold;
    out_if.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        if (holds_done != hold_reqs) begin
          out_if.ready <= 1'b0;
          for (hold = 0; hold < HOLD_CYCLES; hold++) @(negedge clk);
          holds_done++;
        end
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= (k % 3 == 0);
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    int  p;
    int  len;
    int  phase_start;
    bit  flip_done;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    dbl_setting     = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.has_byte  = 1'b0;
    in_if.is_last   = 1'b0;
    burst_left      = 0;
    items_sent      = 0;
    hold_reqs       = 0;
    holds_done      = 0;
    flip_done       = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    write_cfg(1'b0);

    // Plain mode: empty message, "abc", extreme bytes with a stray empty
    // beat and a closing beat without a byte.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    settle();
    write_cfg(1'b1);

    // Double mode: empty message, one-byte message, and a short one.
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h3C, 1'b0, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'hC3, 1'b0, 1'b1);
    settle();

    // Random phases: plain, double with a long receiver hold-off, a mode
    // change in the middle of a message, then a random mode. The hold-off
    // phase keeps offering beats until the hold-off is over.
    for (p = 0; p < 4; p++) begin
      case (p)
        0:       write_cfg(1'b0);
        1:       write_cfg(1'b1);
        default: write_cfg(1'($urandom_range(0, 1)));
      endcase
      if (p == 1) hold_reqs++;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS ||
             (p == 1 && holds_done != hold_reqs)) begin
        len = pick_length();
        if (p == 2 && !flip_done && len >= 2) begin
          send_message(len, 1'b1);
          flip_done = 1'b1;
        end else begin
          send_message(len, 1'b0);
        end
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### sha256_message_hasher_core.f
rtl/shamh_pkg.sv
rtl/shamh_if.sv
rtl/shamh_sched.sv
rtl/shamh_compress.sv
rtl/sha256_message_hasher_core.sv
dv/sha256_digest_check.sv
dv/tb_top.sv
